// ----- sv/vh256_pkg.sv -----
`default_nettype none

package vh256_pkg;

	localparam int CoordW = 16;
	localparam int MagW = 15;
	localparam int QuoW = 14;
	localparam int DivSteps = QuoW;
	localparam int HeadW = 8;
	localparam int TabN = 32;
	localparam int IdxW = 7;

	localparam logic [16:0] HALVE_LIMIT = 17'd8000;
	localparam logic [QuoW-1:0] GRAD_SAT = 14'h3FFF;

	localparam logic [1:0] QUAD_POS_POS = 2'd0;
	localparam logic [1:0] QUAD_NEG_NEG = 2'd3;

	localparam logic [HeadW-1:0] QUAD_BASE [4] = '{8'h40, 8'h80, 8'h00, 8'hC0};
	localparam logic [IdxW-1:0] OCT_MIRROR = 7'd64;

	localparam logic [15:0] SLOPE_TAB [TabN] = '{
		16'h3FFF, 16'h28BC, 16'h145A, 16'h0D8E, 16'h0A27, 16'h081B, 16'h06BD, 16'h05C3,
		16'h0506, 16'h0474, 16'h03FE, 16'h039D, 16'h034B, 16'h0306, 16'h02CB, 16'h0297,
		16'h026A, 16'h0241, 16'h021D, 16'h01FC, 16'h01DE, 16'h01C3, 16'h01AB, 16'h0194,
		16'h017F, 16'h016B, 16'h0159, 16'h0148, 16'h0137, 16'h0128, 16'h011A, 16'h010C
	};

	typedef struct packed {
		logic [1:0] quad;
		logic       ge;
		logic       ovf;
	} side_t;

	typedef struct packed {
		logic [MagW-1:0] rem;
		logic [MagW-1:0] dvs;
		logic [QuoW-1:0] num;
		logic [QuoW-1:0] quo;
	} div_t;

endpackage

`default_nettype wire

// ----- sv/vector_heading_256.sv -----
// Channel   Role    Handshake             Payload
// pt        input   pt_valid / pt_ready   from_x, from_y, to_x, to_y (16 bits each)
// hd        output  hd_valid / hd_ready   heading (8 bits)
//
// One transaction per cycle while hd is not stalled; the path from the pt
// transaction to heading valid has two front stages, 14 divider cells and one
// table stage. The divider chain, one quotient bit per cell, sets the depth.
// Reset clears only the valid bits of every stage; payload is not reset.
// A stalled hd output freezes the whole chain, so pt_ready drops with it.
`default_nettype none

module vector_heading_256
	import vh256_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pt_valid,
	output logic                   pt_ready,
	input  wire logic [CoordW-1:0] from_x,
	input  wire logic [CoordW-1:0] from_y,
	input  wire logic [CoordW-1:0] to_x,
	input  wire logic [CoordW-1:0] to_y,
	output logic                   hd_valid,
	input  wire logic              hd_ready,
	output logic [HeadW-1:0]       heading
);

	// Advance the whole chain whenever the output register is empty or being
	// drained; hold every stage otherwise.
	logic  adv;

	// Chain taps: index 0 is the front output, index DivSteps the last cell.
	logic  cell_v    [DivSteps+1];
	side_t cell_side [DivSteps+1];
	div_t  cell_data [DivSteps+1];

	assign adv = !hd_valid || hd_ready;
	assign pt_ready = adv;

	// Difference, magnitude, halving, quadrant and operand ordering.
	vh256_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (pt_valid),
		.from_x   (from_x),
		.from_y   (from_y),
		.to_x     (to_x),
		.to_y     (to_y),
		.out_v    (cell_v[0]),
		.out_side (cell_side[0]),
		.out_data (cell_data[0])
	);

	// Row of restoring-division cells: each resolves one quotient bit of
	// (larger << 8) / smaller and hands remainder and operands to the next.
	for (genvar k = 0; k < DivSteps; k++) begin : g_cell
		vh256_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_v     (cell_v[k]),
			.in_side  (cell_side[k]),
			.in_data  (cell_data[k]),
			.out_v    (cell_v[k+1]),
			.out_side (cell_side[k+1]),
			.out_data (cell_data[k+1])
		);
	end

	// Gradient table search, octant mirror, quadrant offset; output register.
	vh256_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (cell_v[DivSteps]),
		.in_side  (cell_side[DivSteps]),
		.in_quo   (cell_data[DivSteps].quo),
		.out_v    (hd_valid),
		.out_head (heading)
	);

	// The last cell keeps a proper remainder whenever the quotient is used.
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[DivSteps] && !cell_side[DivSteps].ovf |->
		cell_data[DivSteps].rem < cell_data[DivSteps].dvs)
		else $error("divider remainder not below divisor");

	// A stall freezes the occupancy of the divider row.
	a_stall_holds_row: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cell_v[DivSteps]) && $stable(cell_v[0]))
		else $error("divider row moved during stall");

	// A quotient overflow arises only when the divisor is below 2^9.
	a_ovf_small_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[0] && cell_side[0].ovf |-> cell_data[0].dvs[MagW-1:9] == '0)
		else $error("overflow flagged with large divisor");

endmodule

`default_nettype wire

// ----- sv/vh256_front.sv -----
`default_nettype none

module vh256_front
	import vh256_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_v,
	input  wire logic [CoordW-1:0] from_x,
	input  wire logic [CoordW-1:0] from_y,
	input  wire logic [CoordW-1:0] to_x,
	input  wire logic [CoordW-1:0] to_y,
	output logic                   out_v,
	output side_t                  out_side,
	output div_t                   out_data
);

	logic              v_s1;
	logic [CoordW-1:0] dx_s1;
	logic [CoordW-1:0] dy_s1;

	logic [CoordW-1:0] ax;
	logic [CoordW-1:0] ay;
	logic [16:0]       asum;
	logic              halve;
	logic [CoordW-1:0] hx;
	logic [CoordW-1:0] hy;
	logic [MagW-1:0]   mx;
	logic [MagW-1:0]   my;
	logic [MagW-1:0]   big;
	logic [MagW-1:0]   sml;
	logic              ge;
	logic              ovf;
	side_t             side_d;
	div_t              data_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
		end
	end

	// wrapped 16-bit differences, target minus start
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= to_x - from_x;
			dy_s1 <= to_y - from_y;
		end
	end

	always_comb begin
		ax = dx_s1[CoordW-1] ? (~dx_s1 + 16'd1) : dx_s1;
		ay = dy_s1[CoordW-1] ? (~dy_s1 + 16'd1) : dy_s1;
		asum = {1'b0, ax} + {1'b0, ay};
		halve = asum > HALVE_LIMIT;
		hx = halve ? (ax >> 1) : ax;
		hy = halve ? (ay >> 1) : ay;
		mx = hx[MagW-1:0];
		my = hy[MagW-1:0];
		ge = mx >= my;
		big = ge ? mx : my;
		sml = ge ? my : mx;
		// quotient would reach 2^14: covers a zero divisor as well
		ovf = {6'd0, big} >= {sml, 6'd0};
		side_d.quad[1] = dy_s1[CoordW-1] || (my == '0);
		side_d.quad[0] = dx_s1[CoordW-1] && (mx != '0);
		side_d.ge = ge;
		side_d.ovf = ovf;
		data_d.rem = {6'd0, big[MagW-1:6]};
		data_d.dvs = sml;
		data_d.num = {big[5:0], 8'd0};
		data_d.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_side <= side_d;
			out_data <= data_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/vh256_div_cell.sv -----
`default_nettype none

module vh256_div_cell
	import vh256_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  in_v,
	input  wire side_t in_side,
	input  wire div_t  in_data,
	output logic       out_v,
	output side_t      out_side,
	output div_t       out_data
);

	logic [MagW:0]   r2;
	logic [MagW+1:0] diff;
	logic            take;
	div_t            data_d;

	// one restoring step: bring down the next numerator bit, subtract if it fits
	always_comb begin
		r2 = {in_data.rem, in_data.num[QuoW-1]};
		diff = {1'b0, r2} - {2'b00, in_data.dvs};
		take = !diff[MagW+1];
		data_d.rem = take ? diff[MagW-1:0] : r2[MagW-1:0];
		data_d.dvs = in_data.dvs;
		data_d.num = {in_data.num[QuoW-2:0], 1'b0};
		data_d.quo = {in_data.quo[QuoW-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_side <= in_side;
			out_data <= data_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/vh256_back.sv -----
`default_nettype none

module vh256_back
	import vh256_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_v,
	input  wire side_t            in_side,
	input  wire logic [QuoW-1:0]  in_quo,
	output logic                  out_v,
	output logic [HeadW-1:0]      out_head
);

	logic [QuoW-1:0]  grad;
	logic [IdxW-1:0]  idx;
	logic [IdxW-1:0]  oct;
	logic [HeadW-1:0] head_d;

	always_comb begin
		grad = in_side.ovf ? GRAD_SAT : in_quo;
		// first entry of the descending table at or below the gradient
		idx = IdxW'(TabN);
		for (int i = TabN - 1; i >= 0; i--) begin
			if (SLOPE_TAB[i] <= {2'b00, grad}) begin
				idx = IdxW'(i);
			end
		end
		oct = in_side.ge ? (OCT_MIRROR - idx) : idx;
		if (in_side.quad == QUAD_POS_POS || in_side.quad == QUAD_NEG_NEG) begin
			head_d = QUAD_BASE[in_side.quad] + HeadW'(OCT_MIRROR) - {1'b0, oct};
		end else begin
			head_d = QUAD_BASE[in_side.quad] + {1'b0, oct};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_head <= head_d;
		end
	end

endmodule

`default_nettype wire
